// File: rtl/stm_pkg.sv
package stm_pkg;

  // Fixed widths of the channel fields.
  localparam int CHAR_W       = 8;
  localparam int FIELD_TEXT_W = 64;
  localparam int FIELD_LEN_W  = 4;
  localparam int OP_W         = 2;
  localparam int IDX_W        = 2;
  localparam int MASK_W       = 4;

  // Defaults for the top level parameters.
  localparam int DEF_ENTRIES   = 4;
  localparam int DEF_MAX_CHARS = 8;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_STORE    = 2'd0,
    OP_CONTAINS = 2'd1,
    OP_STARTS   = 2'd2,
    OP_ENDS     = 2'd3
  } op_t;

endpackage

// File: rtl/stm_if.sv
interface stm_in_if import stm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic [IDX_W-1:0]        entry_index;
  logic [FIELD_TEXT_W-1:0] text_chars;
  logic [FIELD_LEN_W-1:0]  text_length;

  modport source (output valid, output opcode, output entry_index, output text_chars,
                  output text_length, input ready);
  modport sink   (input valid, input opcode, input entry_index, input text_chars,
                  input text_length, output ready);
endinterface

interface stm_out_if import stm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] match_mask;

  modport source (output valid, output match_mask, input ready);
  modport sink   (input valid, input match_mask, output ready);
endinterface

// File: rtl/string_table_match.sv
// String table match.
// The input channel in_ch carries one word per item: opcode, entry_index,
// text_chars and text_length. A store word (opcode 0) writes the characters
// and length of one table entry and returns nothing. A query word (contains,
// starts-with or ends-with) returns one word on out_ch whose match_mask has
// bit i set when entry i matches the key. Lengths above MAX_CHARS saturate.
// An empty key matches every entry.
// A query word accepted on in_ch is written into a slot of the two-entry
// queue; the back end pops it from there, and its combinational comparators
// load the output register that drives out_ch. Throughput is one word per
// cycle while the receiver is ready, set by the parallel comparators in the
// back end and the queue between.
// Reset clears every entry to an empty string and empties the queue and
// the output register; no word is in flight afterward.
// When the receiver stalls, the result word holds on out_ch; stores still
// drain from the queue, and the input keeps taking words until the queue
// fills, after which in_ch.ready drops.
module string_table_match import stm_pkg::*; #(
  parameter int ENTRIES   = DEF_ENTRIES,
  parameter int MAX_CHARS = DEF_MAX_CHARS
) (
  input  logic      clk,
  input  logic      rst_n,
  stm_in_if.sink    in_ch,
  stm_out_if.source out_ch
);

  // Widths that follow from the table width.
  localparam int LEN_W  = $clog2(MAX_CHARS + 1);
  localparam int KEY_W  = MAX_CHARS * CHAR_W;
  localparam int ITEM_W = OP_W + IDX_W + LEN_W + KEY_W;

  // Front end to queue.
  logic              push_valid;
  logic              push_ready;
  logic [ITEM_W-1:0] push_data;

  // Queue to back end.
  logic              pop_valid;
  logic              pop_ready;
  logic [ITEM_W-1:0] pop_data;

  // The front end saturates the length and clears the characters past it.
  stm_front #(
    .MAX_CHARS (MAX_CHARS),
    .LEN_W     (LEN_W),
    .KEY_W     (KEY_W),
    .ITEM_W    (ITEM_W)
  ) u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // The queue lets the front keep accepting words while a result is stalled.
  stm_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The back end holds the table, runs the comparators and owns the output register.
  stm_back #(
    .ENTRIES   (ENTRIES),
    .MAX_CHARS (MAX_CHARS),
    .LEN_W     (LEN_W),
    .KEY_W     (KEY_W),
    .ITEM_W    (ITEM_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

// File: rtl/stm_front.sv
module stm_front import stm_pkg::*; #(
  parameter int MAX_CHARS = DEF_MAX_CHARS,
  parameter int LEN_W     = $clog2(MAX_CHARS + 1),
  parameter int KEY_W     = MAX_CHARS * CHAR_W,
  parameter int ITEM_W    = OP_W + IDX_W + LEN_W + KEY_W
) (
  stm_in_if.sink            in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output logic [ITEM_W-1:0] push_data
);

  logic [LEN_W-1:0] len_c;
  logic [KEY_W-1:0] key_c;
  op_t              op_c;

  // Lengths saturate at the table width; characters past the length read as zero.
  always_comb begin
    if (in_ch.text_length > FIELD_LEN_W'(MAX_CHARS)) begin
      len_c = LEN_W'(MAX_CHARS);
    end else begin
      len_c = LEN_W'(in_ch.text_length);
    end
    for (int b = 0; b < MAX_CHARS; b++) begin
      if (b < int'(len_c)) begin
        key_c[b*CHAR_W +: CHAR_W] = in_ch.text_chars[b*CHAR_W +: CHAR_W];
      end else begin
        key_c[b*CHAR_W +: CHAR_W] = '0;
      end
    end
    op_c = op_t'(in_ch.opcode);
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;
  assign push_data   = {op_c, in_ch.entry_index, len_c, key_c};

endmodule

// File: rtl/stm_queue.sv
module stm_queue import stm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_fire, pop_fire;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/stm_back.sv
module stm_back import stm_pkg::*; #(
  parameter int ENTRIES   = DEF_ENTRIES,
  parameter int MAX_CHARS = DEF_MAX_CHARS,
  parameter int LEN_W     = $clog2(MAX_CHARS + 1),
  parameter int KEY_W     = MAX_CHARS * CHAR_W,
  parameter int ITEM_W    = OP_W + IDX_W + LEN_W + KEY_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  logic [ITEM_W-1:0] pop_data,
  stm_out_if.source         out_ch
);

  // Only entries that a store can reach and the mask can report are kept.
  localparam int USED = (ENTRIES < MASK_W) ? ENTRIES : MASK_W;

  op_t              op;
  logic [IDX_W-1:0] idx;
  logic [LEN_W-1:0] len;
  logic [KEY_W-1:0] key;
  logic             is_store, pop_fire;

  logic [KEY_W-1:0]  ent_text_r [USED];
  logic [LEN_W-1:0]  ent_len_r  [USED];
  logic [MASK_W-1:0] mask_c;
  logic [MASK_W-1:0] mask_r;
  logic              out_valid_r, out_valid_nxt;

  assign op  = op_t'(pop_data[ITEM_W-1 -: OP_W]);
  assign idx = pop_data[ITEM_W-OP_W-1 -: IDX_W];
  assign len = pop_data[KEY_W +: LEN_W];
  assign key = pop_data[KEY_W-1:0];

  assign is_store  = (op == OP_STORE);
  assign pop_ready = is_store || !out_valid_r || out_ch.ready;
  assign pop_fire  = pop_valid && pop_ready;

  // Every entry is tested at every offset at once; hit marks offsets where the key lines up.
  always_comb begin
    int                   n_i;
    int                   k_i;
    logic                 ok;
    logic                 sel;
    logic                 cont;
    logic                 strt;
    logic                 endw;
    logic [MAX_CHARS-1:0] hit;
    mask_c = '0;
    k_i    = int'(len);
    for (int e = 0; e < USED; e++) begin
      n_i = int'(ent_len_r[e]);
      for (int p = 0; p < MAX_CHARS; p++) begin
        ok = 1'b1;
        for (int j = 0; j < MAX_CHARS - p; j++) begin
          if (j < k_i &&
              ent_text_r[e][(p+j)*CHAR_W +: CHAR_W] != key[j*CHAR_W +: CHAR_W]) begin
            ok = 1'b0;
          end
        end
        hit[p] = ok;
      end
      cont = 1'b0;
      endw = 1'b0;
      for (int p = 0; p < MAX_CHARS; p++) begin
        if (p + k_i <= n_i) begin
          cont = cont | hit[p];
        end
        if (p + k_i == n_i) begin
          endw = endw | hit[p];
        end
      end
      strt = hit[0] && (k_i <= n_i);
      unique case (op)
        OP_CONTAINS: sel = cont;
        OP_STARTS:   sel = strt;
        OP_ENDS:     sel = endw;
        OP_STORE:    sel = 1'b0;
      endcase
      mask_c[e] = (k_i == 0) || sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < USED; e++) begin
        ent_text_r[e] <= '0;
        ent_len_r[e]  <= '0;
      end
    end else if (pop_fire && is_store) begin
      for (int e = 0; e < USED; e++) begin
        if (idx == IDX_W'(e)) begin
          ent_text_r[e] <= key;
          ent_len_r[e]  <= len;
        end
      end
    end
  end

  always_comb begin
    if (pop_fire && !is_store) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire && !is_store) begin
      mask_r <= mask_c;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.match_mask = mask_r;

`ifndef SYNTH
  a_query_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_fire && !is_store) |=> out_valid_r)
    else $error("query left the queue without a result word");

  a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_fire && is_store && !(out_valid_r && !out_ch.ready)) |=> !out_valid_r)
    else $error("store produced a result word");

  a_no_pop_over_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && pop_valid && !is_store) |-> !pop_ready)
    else $error("query taken while result word stalled");

  a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ent_len_r[0] <= LEN_W'(MAX_CHARS))
    else $error("stored length beyond table width");
`endif

endmodule

// File: sim/string_table_match_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the string table matcher.
//
// An initial block fills a queue of pending words. It starts with a short
// directed list that covers the corner cases, then adds a long random list.
// A clocked driver offers those words on in_ch and inserts random idle
// bursts. When a word is accepted, the driver runs it through a local model
// of the table. A store updates the model's copy of the entry. A query
// pushes the mask it should produce onto mask_due. A clocked monitor pops
// the oldest mask for every result word taken from out_ch and compares the
// two. A separate process drives out_ch.ready: it stalls in random bursts,
// and once it holds off for a long stretch so that the block fills up.
module string_table_match_tb;
  import stm_pkg::*;

  localparam int NUM_ENTRIES = 4;
  localparam int MAX_LEN     = 8;
  localparam int RAND_WORDS  = 1030;
  localparam int CALM_TAIL   = 150;  // final words sent with no idling
  localparam int LONG_HOLD   = 80;   // cycles of the long receiver hold-off
  localparam int HOLD_AT     = 350;  // accepted words before that hold-off
  localparam int END_PAUSE   = 10;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    op_t                     opcode;
    logic [IDX_W-1:0]        entry_index;
    logic [FIELD_TEXT_W-1:0] text_chars;
    logic [FIELD_LEN_W-1:0]  text_length;
    bit                      drain_first;  // wait until no result is owed
  } word_t;

  logic clk;
  logic rst_n;

  stm_in_if  in_ch ();
  stm_out_if out_ch ();

  string_table_match DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Words waiting to be driven, and the word currently on the bus.
  word_t pending[$];
  word_t cur;
  int    word_total;

  // Masks owed by the block, oldest first.
  logic [MASK_W-1:0] mask_due[$];

  // Table copy used by the checker. It is updated when a word is accepted.
  logic [FIELD_TEXT_W-1:0] tbl_text[NUM_ENTRIES];
  int                      tbl_len[NUM_ENTRIES];

  // Table copy used by the stimulus builder. Keys are cut from the entries
  // so that queries hit often.
  logic [FIELD_TEXT_W-1:0] plan_text[NUM_ENTRIES];
  int                      plan_len[NUM_ENTRIES];

  int sent;
  int idle_left;
  int hold_left;
  bit long_hold_done;
  int cycles;
  int bad_words;
  int n_stores, n_queries, n_results, n_hit_results, n_full_results;

  function automatic int sat_len(logic [FIELD_LEN_W-1:0] len);
    return (len > MAX_LEN) ? MAX_LEN : int'(len);
  endfunction

  // Mask that a query should return against the checker's table copy.
  // Only bytes below each length take part in a comparison. A key longer
  // than an entry never matches it, and for ends-with this covers the case
  // where the key would start before the entry.
  function automatic logic [MASK_W-1:0] table_hits(op_t op,
                                                   logic [FIELD_TEXT_W-1:0] key,
                                                   logic [FIELD_LEN_W-1:0] len);
    logic [MASK_W-1:0] hits;
    int klen, n, first, last;
    bit same;
    hits = '0;
    klen = sat_len(len);
    for (int e = 0; e < NUM_ENTRIES && e < MASK_W; e++) begin
      n = tbl_len[e];
      if (klen == 0) begin
        hits[e] = 1'b1;
      end else if (klen <= n) begin
        first = (op == OP_ENDS) ? n - klen : 0;
        last  = (op == OP_CONTAINS) ? n - klen : first;
        for (int p = first; p <= last; p++) begin
          same = 1'b1;
          for (int j = 0; j < klen; j++) begin
            if (tbl_text[e][8*(p+j) +: 8] != key[8*j +: 8]) same = 1'b0;
          end
          if (same) hits[e] = 1'b1;
        end
      end
    end
    return hits;
  endfunction

  // Characters come mostly from a tiny alphabet with a zero byte in it, so
  // that substrings repeat and zero bytes appear inside strings.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 5))
      0, 1:    return 8'h61;
      2, 3:    return 8'h62;
      4:       return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random string of n characters. The bytes above it are junk, which the
  // block must ignore.
  function automatic logic [FIELD_TEXT_W-1:0] make_text(int n);
    logic [FIELD_TEXT_W-1:0] t;
    for (int b = 0; b < MAX_LEN; b++) begin
      t[8*b +: 8] = (b < n) ? pick_char() : 8'($urandom_range(0, 255));
    end
    return t;
  endfunction

  task automatic add_word(op_t op, int idx, logic [FIELD_TEXT_W-1:0] chars,
                          int len, bit drain);
    word_t w;
    w.opcode      = op;
    w.entry_index = IDX_W'(idx);
    w.text_chars  = chars;
    w.text_length = FIELD_LEN_W'(len);
    w.drain_first = drain;
    pending.push_back(w);
    if (op == OP_STORE) begin
      plan_text[idx] = chars;
      plan_len[idx]  = sat_len(w.text_length);
    end
  endtask

  // Random query. Most keys are cut from a current entry at the position
  // that the mode tests, with the odd bit flipped. The rest are short keys
  // from the alphabet or fully random words.
  task automatic add_random_query(bit drain);
    logic [FIELD_TEXT_W-1:0] key;
    op_t op;
    int kind, e, n, klen, off, len, b;
    op   = op_t'($urandom_range(1, 3));
    kind = $urandom_range(0, 19);
    if (kind < 12) begin
      e    = $urandom_range(0, NUM_ENTRIES - 1);
      n    = plan_len[e];
      klen = $urandom_range(0, n);
      case (op)
        OP_STARTS: off = 0;
        OP_ENDS:   off = n - klen;
        default:   off = $urandom_range(0, n - klen);
      endcase
      key = plan_text[e] >> (8 * off);
      for (b = klen; b < MAX_LEN; b++) key[8*b +: 8] = 8'($urandom_range(0, 255));
      if (klen > 0 && $urandom_range(0, 9) == 0) begin
        key[$urandom_range(0, 8 * klen - 1)] ^= 1'b1;
      end
      len = klen;
      if (klen == MAX_LEN && $urandom_range(0, 1) == 1) len = $urandom_range(9, 15);
    end else if (kind < 17) begin
      len = $urandom_range(0, 4);
      key = make_text(len);
    end else begin
      len = $urandom_range(0, 15);
      key = {$urandom, $urandom};
    end
    add_word(op, $urandom_range(0, 3), key, len, drain);
  endtask

  task automatic add_random_store(bit drain);
    logic [FIELD_TEXT_W-1:0] chars;
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    if ($urandom_range(0, 6) == 0) chars = {$urandom, $urandom};
    else chars = make_text((len > MAX_LEN) ? MAX_LEN : len);
    add_word(OP_STORE, $urandom_range(0, 3), chars, len, drain);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stimulus and end of run.
  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = '0;
    in_ch.entry_index = '0;
    in_ch.text_chars  = '0;
    in_ch.text_length = '0;
    out_ch.ready      = 1'b0;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      plan_text[e] = '0;
      plan_len[e]  = 0;
    end

    // Against the empty table after reset, an empty key matches everything
    // and any non-empty key matches nothing.
    add_word(OP_CONTAINS, 0, 64'hDEAD_BEEF_0BAD_F00D, 0, 0);
    add_word(OP_STARTS,   1, 64'h0000_0000_0000_0061, 1, 0);
    // Full entry, saturated length, a zero byte inside the length with junk
    // above it, and an empty entry whose junk must not be kept.
    add_word(OP_STORE, 0, 64'h6867_6665_6463_6261, 8, 0);
    add_word(OP_STORE, 1, 64'hFFFF_FFFF_FFFF_FFFF, 15, 0);
    add_word(OP_STORE, 2, 64'hA5A5_A5A5_6300_6261, 4, 0);
    add_word(OP_STORE, 3, 64'h1234_5678_9ABC_DEF0, 0, 0);
    add_word(OP_CONTAINS, 0, 64'h0000_0000_0000_6463, 2, 0);
    add_word(OP_STARTS,   0, 64'hFFFF_0000_0000_6261, 2, 0);
    add_word(OP_ENDS,     0, 64'h0000_0000_0000_6867, 2, 0);
    add_word(OP_ENDS,     0, 64'h6867_6665_6463_6261, 8, 0);
    add_word(OP_CONTAINS, 0, 64'h6867_6665_6463_6261, 12, 0);
    add_word(OP_CONTAINS, 0, 64'h0000_0000_0000_6300, 2, 0);
    // Ends-with key one longer than the four-character entry.
    add_word(OP_ENDS,     0, 64'h0000_0063_0062_6161, 5, 0);
    add_word(OP_CONTAINS, 0, 64'hFFFF_FFFF_FFFF_FFFF, 12, 0);
    add_word(OP_STARTS,   0, 64'h0000_0000_0000_0000, 1, 0);
    add_word(OP_CONTAINS, 0, 64'h0000_0000_0000_0000, 1, 0);
    add_word(OP_ENDS,     0, 64'h0000_0000_0000_0063, 1, 0);
    add_word(OP_STARTS,   0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    add_word(OP_ENDS,     0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    add_word(OP_STORE,    3, 64'hFFFF_FFFF_FFFF_FF68, 1, 0);
    add_word(OP_CONTAINS, 0, 64'h0000_0000_0000_0068, 1, 0);
    add_word(OP_CONTAINS, 0, 64'h0000_0000_0000_00FF, 1, 0);
    add_word(OP_ENDS,     0, 64'hFFFF_FFFF_FFFF_FFFF, 8, 0);

    // Random part. Roughly a third are stores, so the table keeps changing.
    // Twice the sender waits until every owed result has come.
    for (int i = 0; i < RAND_WORDS; i++) begin
      if ($urandom_range(0, 9) < 3) add_random_store(i == 450 || i == 700);
      else add_random_query(i == 450 || i == 700);
    end
    word_total = pending.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_ch.valid || mask_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (END_PAUSE) @(posedge clk);

    $display("Sent %0d words: %0d stores and %0d queries over a changing table.",
             word_total, n_stores, n_queries);
    $display("Checked %0d result words: %0d with some entry matching, %0d with all.",
             n_results, n_hit_results, n_full_results);
    if (bad_words == 0) begin
      $display("string_table_match: match");
    end else begin
      $display("%0d result words were wrong.", bad_words);
      $display("string_table_match: mismatch");
    end
    $finish;
  end

  // Driver. When a word is accepted, it is applied to the checker's table.
  // Whenever the bus is free, the driver either idles or puts the next
  // pending word on it. Idle bursts run only in some windows and never in
  // the final stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      sent        = 0;
      idle_left   = 0;
      n_stores    = 0;
      n_queries   = 0;
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        tbl_text[e] = '0;
        tbl_len[e]  = 0;
      end
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sent++;
        if (cur.opcode == OP_STORE) begin
          tbl_text[cur.entry_index] = cur.text_chars;
          tbl_len[cur.entry_index]  = sat_len(cur.text_length);
          n_stores++;
        end else begin
          mask_due.push_back(table_hits(cur.opcode, cur.text_chars, cur.text_length));
          n_queries++;
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (idle_left != 0) begin
          idle_left--;
          in_ch.valid <= 1'b0;
        end else if (pending.size() == 0 ||
                     (pending[0].drain_first && mask_due.size() != 0)) begin
          in_ch.valid <= 1'b0;
        end else if (sent < word_total - CALM_TAIL && (sent / 100) % 4 != 3 &&
                     $urandom_range(0, 7) == 0) begin
          idle_left = $urandom_range(1, 9) - 1;
          in_ch.valid <= 1'b0;
        end else begin
          cur = pending.pop_front();
          in_ch.opcode      <= cur.opcode;
          in_ch.entry_index <= cur.entry_index;
          in_ch.text_chars  <= cur.text_chars;
          in_ch.text_length <= cur.text_length;
          in_ch.valid       <= 1'b1;
        end
      end
    end
  end

  // Receiver. It stalls in random bursts, except in quiet windows and in the
  // final stretch. After HOLD_AT accepted words it holds off once for a long
  // stretch set by LONG_HOLD, while the driver keeps offering words.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready   <= 1'b0;
      hold_left      = 0;
      long_hold_done = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!long_hold_done && sent >= HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else if (sent < word_total - CALM_TAIL && (sent / 100) % 4 != 1 &&
                 $urandom_range(0, 6) == 0) begin
      hold_left = $urandom_range(1, 9) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor. Each result word is checked against the oldest owed mask.
  // A result with no mask owed also counts as an error.
  always @(posedge clk) begin
    if (!rst_n) begin
      bad_words      = 0;
      n_results      = 0;
      n_hit_results  = 0;
      n_full_results = 0;
    end else if (out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.match_mask != '0) n_hit_results++;
      if (out_ch.match_mask == '1) n_full_results++;
      if (mask_due.size() == 0) begin
        bad_words++;
        if (bad_words <= 10) begin
          $display("Unexpected result word: match_mask %b", out_ch.match_mask);
        end
      end else if (out_ch.match_mask !== mask_due[0]) begin
        bad_words++;
        if (bad_words <= 10) begin
          $display("Result word %0d: match_mask expected %b, got %b",
                   n_results, mask_due[0], out_ch.match_mask);
        end
        void'(mask_due.pop_front());
      end else begin
        void'(mask_due.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results owed.",
               cycles, mask_due.size());
      $display("string_table_match: mismatch");
      $finish;
    end
  end

  initial cycles = 0;

endmodule
